// File: hdl/cht_pkg.sv
`default_nettype none

package cht_pkg;

  localparam int unsigned BUCKET_COUNT = 256;
  localparam int unsigned POOL_ENTRIES = 256;
  localparam int unsigned BUCKET_W     = $clog2(BUCKET_COUNT);
  localparam int unsigned HANDLE_W     = 8;
  localparam int unsigned KEY_W        = 32;
  localparam int unsigned LINK_W       = HANDLE_W + 1;
  localparam int unsigned STEP_W       = $clog2(POOL_ENTRIES);
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned ADDR_W       = 5;
  localparam int unsigned REG_SEL_W    = 3;

  typedef enum logic [2:0] {
    KIND_FIND       = 3'd0,
    KIND_FIND_INODE = 3'd1,
    KIND_FIND_BLOCK = 3'd2,
    KIND_INSERT     = 3'd3,
    KIND_REMOVE     = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_MISMATCH  = 2'd2
  } status_e;

  typedef enum logic [REG_SEL_W-1:0] {
    REG_DIR_LOW     = 3'd0,
    REG_DIR_LIMIT   = 3'd1,
    REG_FILE_LOW    = 3'd2,
    REG_FILE_LIMIT  = 3'd3,
    REG_BLOCK_LOW   = 3'd4,
    REG_BLOCK_LIMIT = 3'd5
  } reg_sel_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HEAD_RD,
    S_HEAD_CK,
    S_NODE_CK,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [KEY_W-1:0] dir_low;
    logic [KEY_W-1:0] dir_limit;
    logic [KEY_W-1:0] file_low;
    logic [KEY_W-1:0] file_limit;
    logic [KEY_W-1:0] block_low;
    logic [KEY_W-1:0] block_limit;
  } cfg_t;

  typedef struct packed {
    logic latch;
    logic head_rd;
    logic insert_wr;
    logic node_first;
    logic node_next;
    logic unlink;
    logic set_hit;
    logic set_mismatch;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    kind_e kind;
    logic  mismatch;
    logic  head_valid;
    logic  key_match;
    logic  node_is_handle;
    logic  link_valid;
    logic  steps_last;
    logic  out_free;
  } sts_t;

endpackage

`default_nettype wire

// File: hdl/chained_hash_id_table.sv
// Chained hash table mapping 32-bit object ids to 8-bit entry handles.
// Requests enter on the s_axis channel: tuser carries the kind (find, find
// inode, find block, insert, remove), tdata the key and the handle. Each
// request yields exactly one result on the m_axis channel: tuser carries the
// status, tdata the found handle and the three id class flags.
// The APB port holds the six id range registers; write them while idle.
// One request is in work at a time. A typed find with a class mismatch or an
// unused kind goes from the head read state straight to the response; an
// insert or a walk of an empty bucket reads the bucket head first; a find or
// remove that examines chain entries then follows the chain one link per
// read of the link and key memories. The next request
// is accepted in the cycle after its result is loaded.
// Reset empties every bucket through per-bucket valid bits at once, so the
// block accepts requests right after reset; entry memories need no clearing.
// When the receiver stalls, the result waits in the output register and the
// next request may be accepted and worked up to its own result, which then
// waits until the output register frees.
`default_nettype none

module chained_hash_id_table (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // key [31:0], handle [39:32]
  input  wire logic [39:0]                s_axis_tdata_i,
  // kind [2:0]
  input  wire logic [2:0]                 s_axis_tuser_i,
  output logic                            m_axis_tvalid_o,
  input  wire logic                       m_axis_tready_i,
  // found_handle [7:0], is_dir [8], is_file [9], is_block [10], zero [15:11]
  output logic [15:0]                     m_axis_tdata_o,
  // status [1:0]
  output logic [1:0]                      m_axis_tuser_o,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [cht_pkg::ADDR_W-1:0] paddr,
  input  wire logic [cht_pkg::DATA_W-1:0] pwdata,
  output logic      [cht_pkg::DATA_W-1:0] prdata,
  output logic                            pready
);

  cht_pkg::cfg_t                cfg;
  cht_pkg::cmd_t                cmd;
  cht_pkg::sts_t                sts;
  logic [cht_pkg::HANDLE_W-1:0] out_handle;
  logic                         out_dir, out_file, out_block;

  cht_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  cht_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cht_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .in_kind_i      (s_axis_tuser_i),
    .in_key_i       (s_axis_tdata_i[31:0]),
    .in_handle_i    (s_axis_tdata_i[39:32]),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_valid_o    (m_axis_tvalid_o),
    .out_ready_i    (m_axis_tready_i),
    .out_status_o   (m_axis_tuser_o),
    .out_handle_o   (out_handle),
    .out_is_dir_o   (out_dir),
    .out_is_file_o  (out_file),
    .out_is_block_o (out_block)
  );

  assign m_axis_tdata_o = {5'b0, out_block, out_file, out_dir, out_handle};

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("request accepted while a request was still in work");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("result loaded over an untaken result");

  a_unlink_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.unlink |-> (sts.kind == cht_pkg::KIND_REMOVE) && sts.node_is_handle)
    else $error("unlink without a matching remove handle");

  a_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.insert_wr, cmd.unlink, cmd.latch}))
    else $error("conflicting table updates in one cycle");

endmodule

`default_nettype wire

// File: hdl/cht_regs.sv
`default_nettype none

module cht_regs (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [cht_pkg::ADDR_W-1:0] paddr,
  input  wire logic [cht_pkg::DATA_W-1:0] pwdata,
  output logic      [cht_pkg::DATA_W-1:0] prdata,
  output logic                            pready,
  output cht_pkg::cfg_t                   cfg_o
);

  cht_pkg::cfg_t    cfg_q;
  cht_pkg::cfg_t    cfg_d;
  cht_pkg::reg_sel_e sel;
  logic             wr_en;

  assign sel   = cht_pkg::reg_sel_e'(paddr[cht_pkg::ADDR_W-1:2]);
  assign wr_en = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (sel)
        cht_pkg::REG_DIR_LOW:     cfg_d.dir_low     = pwdata;
        cht_pkg::REG_DIR_LIMIT:   cfg_d.dir_limit   = pwdata;
        cht_pkg::REG_FILE_LOW:    cfg_d.file_low    = pwdata;
        cht_pkg::REG_FILE_LIMIT:  cfg_d.file_limit  = pwdata;
        cht_pkg::REG_BLOCK_LOW:   cfg_d.block_low   = pwdata;
        cht_pkg::REG_BLOCK_LIMIT: cfg_d.block_limit = pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      cht_pkg::REG_DIR_LOW:     prdata = cfg_q.dir_low;
      cht_pkg::REG_DIR_LIMIT:   prdata = cfg_q.dir_limit;
      cht_pkg::REG_FILE_LOW:    prdata = cfg_q.file_low;
      cht_pkg::REG_FILE_LIMIT:  prdata = cfg_q.file_limit;
      cht_pkg::REG_BLOCK_LOW:   prdata = cfg_q.block_low;
      cht_pkg::REG_BLOCK_LIMIT: prdata = cfg_q.block_limit;
      default:                  prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// File: hdl/cht_ctrl.sv
`default_nettype none

module cht_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire cht_pkg::sts_t sts_i,
  output cht_pkg::cmd_t      cmd_o
);

  cht_pkg::state_e state_q;
  cht_pkg::state_e state_d;
  logic            is_find;
  logic            hit;

  assign is_find = (sts_i.kind == cht_pkg::KIND_FIND) ||
                   (sts_i.kind == cht_pkg::KIND_FIND_INODE) ||
                   (sts_i.kind == cht_pkg::KIND_FIND_BLOCK);
  assign hit = (sts_i.kind == cht_pkg::KIND_REMOVE) ? sts_i.node_is_handle : sts_i.key_match;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cht_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      cht_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = cht_pkg::S_HEAD_RD;
        end
      end
      cht_pkg::S_HEAD_RD: begin
        if (is_find && sts_i.mismatch) begin
          cmd_o.set_mismatch = 1'b1;
          state_d            = cht_pkg::S_RESP;
        end else if (is_find || sts_i.kind == cht_pkg::KIND_INSERT ||
                     sts_i.kind == cht_pkg::KIND_REMOVE) begin
          cmd_o.head_rd = 1'b1;
          state_d       = cht_pkg::S_HEAD_CK;
        end else begin
          state_d = cht_pkg::S_RESP;
        end
      end
      cht_pkg::S_HEAD_CK: begin
        if (sts_i.kind == cht_pkg::KIND_INSERT) begin
          cmd_o.insert_wr = 1'b1;
          state_d         = cht_pkg::S_RESP;
        end else if (sts_i.head_valid) begin
          cmd_o.node_first = 1'b1;
          state_d          = cht_pkg::S_NODE_CK;
        end else begin
          state_d = cht_pkg::S_RESP;
        end
      end
      cht_pkg::S_NODE_CK: begin
        if (hit) begin
          if (sts_i.kind == cht_pkg::KIND_REMOVE) begin
            cmd_o.unlink = 1'b1;
          end else begin
            cmd_o.set_hit = 1'b1;
          end
          state_d = cht_pkg::S_RESP;
        end else if (!sts_i.link_valid || sts_i.steps_last) begin
          state_d = cht_pkg::S_RESP;
        end else begin
          cmd_o.node_next = 1'b1;
        end
      end
      cht_pkg::S_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = cht_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = cht_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/cht_dp.sv
`default_nettype none

module cht_dp (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire cht_pkg::cfg_t                cfg_i,
  input  wire logic [2:0]                   in_kind_i,
  input  wire logic [cht_pkg::KEY_W-1:0]    in_key_i,
  input  wire logic [cht_pkg::HANDLE_W-1:0] in_handle_i,
  input  wire cht_pkg::cmd_t                cmd_i,
  output cht_pkg::sts_t                     sts_o,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [1:0]                        out_status_o,
  output logic [cht_pkg::HANDLE_W-1:0]      out_handle_o,
  output logic                              out_is_dir_o,
  output logic                              out_is_file_o,
  output logic                              out_is_block_o
);

  cht_pkg::kind_e                kind_q;
  logic [cht_pkg::KEY_W-1:0]     key_q;
  logic [cht_pkg::HANDLE_W-1:0]  handle_q;
  logic                          is_dir_q, is_file_q, is_block_q;
  logic                          is_dir, is_file, is_block;
  cht_pkg::status_e              res_status_q;
  logic [cht_pkg::HANDLE_W-1:0]  res_handle_q;
  logic [cht_pkg::HANDLE_W-1:0]  cur_q, prev_q;
  logic                          at_head_q;
  logic [cht_pkg::STEP_W-1:0]    steps_q;

  logic                          head_vld_q [cht_pkg::BUCKET_COUNT];
  logic [cht_pkg::HANDLE_W-1:0]  head_mem   [cht_pkg::BUCKET_COUNT];
  logic [cht_pkg::LINK_W-1:0]    link_mem   [cht_pkg::POOL_ENTRIES];
  logic [cht_pkg::KEY_W-1:0]     key_mem    [cht_pkg::POOL_ENTRIES];

  logic                          hd_vld_q;
  logic [cht_pkg::HANDLE_W-1:0]  hd_han_q;
  logic [cht_pkg::LINK_W-1:0]    lk_q;
  logic [cht_pkg::KEY_W-1:0]     ek_q;

  logic [cht_pkg::BUCKET_W-1:0]  bucket;
  logic [cht_pkg::HANDLE_W-1:0]  node_addr;
  logic                          head_wr;
  logic                          head_wr_vld;
  logic [cht_pkg::HANDLE_W-1:0]  head_wr_han;
  logic                          link_wr;
  logic [cht_pkg::HANDLE_W-1:0]  link_wr_addr;
  logic [cht_pkg::LINK_W-1:0]    link_wr_data;

  logic                          out_valid_q;
  logic [1:0]                    out_status_q;
  logic [cht_pkg::HANDLE_W-1:0]  out_handle_q;
  logic                          out_dir_q, out_file_q, out_block_q;

  assign is_dir   = (in_key_i >= cfg_i.dir_low)   && (in_key_i < cfg_i.dir_limit);
  assign is_file  = (in_key_i >= cfg_i.file_low)  && (in_key_i < cfg_i.file_limit);
  assign is_block = (in_key_i >= cfg_i.block_low) && (in_key_i < cfg_i.block_limit);

  assign bucket    = key_q[cht_pkg::BUCKET_W-1:0];
  assign node_addr = cmd_i.node_first ? hd_han_q : lk_q[cht_pkg::HANDLE_W-1:0];

  assign head_wr      = cmd_i.insert_wr || (cmd_i.unlink && at_head_q);
  assign head_wr_vld  = cmd_i.insert_wr ? 1'b1 : lk_q[cht_pkg::LINK_W-1];
  assign head_wr_han  = cmd_i.insert_wr ? handle_q : lk_q[cht_pkg::HANDLE_W-1:0];
  assign link_wr      = cmd_i.insert_wr || (cmd_i.unlink && !at_head_q);
  assign link_wr_addr = cmd_i.insert_wr ? handle_q : prev_q;
  assign link_wr_data = cmd_i.insert_wr ? {hd_vld_q, hd_han_q} : lk_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      kind_q    <= cht_pkg::kind_e'(in_kind_i);
      key_q     <= in_key_i;
      handle_q  <= in_handle_i;
      is_dir_q  <= is_dir;
      is_file_q <= is_file;
      is_block_q <= is_block;
    end
    if (cmd_i.latch) begin
      res_status_q <= cht_pkg::ST_NOT_FOUND;
      res_handle_q <= '0;
    end else if (cmd_i.set_mismatch) begin
      res_status_q <= cht_pkg::ST_MISMATCH;
    end else if (cmd_i.set_hit) begin
      res_status_q <= cht_pkg::ST_OK;
      res_handle_q <= cur_q;
    end else if (cmd_i.insert_wr || cmd_i.unlink) begin
      res_status_q <= cht_pkg::ST_OK;
      res_handle_q <= handle_q;
    end
    if (cmd_i.node_first) begin
      cur_q     <= hd_han_q;
      at_head_q <= 1'b1;
      steps_q   <= '0;
    end else if (cmd_i.node_next) begin
      prev_q    <= cur_q;
      cur_q     <= lk_q[cht_pkg::HANDLE_W-1:0];
      at_head_q <= 1'b0;
      steps_q   <= steps_q + cht_pkg::STEP_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < cht_pkg::BUCKET_COUNT; i++) begin
        head_vld_q[i] <= 1'b0;
      end
    end else if (head_wr) begin
      head_vld_q[bucket] <= head_wr_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (head_wr) begin
      head_mem[bucket] <= head_wr_han;
    end
    if (cmd_i.head_rd) begin
      hd_vld_q <= head_vld_q[bucket];
      hd_han_q <= head_mem[bucket];
    end
  end

  always_ff @(posedge clk_i) begin
    if (link_wr) begin
      link_mem[link_wr_addr] <= link_wr_data;
    end
    if (cmd_i.node_first || cmd_i.node_next) begin
      lk_q <= link_mem[node_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.insert_wr) begin
      key_mem[handle_q] <= key_q;
    end
    if (cmd_i.node_first || cmd_i.node_next) begin
      ek_q <= key_mem[node_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_handle_q <= res_handle_q;
      out_dir_q    <= is_dir_q;
      out_file_q   <= is_file_q;
      out_block_q  <= is_block_q;
    end
  end

  assign sts_o.kind           = kind_q;
  assign sts_o.mismatch       = ((kind_q == cht_pkg::KIND_FIND_INODE) && !is_dir_q && !is_file_q)
                              || ((kind_q == cht_pkg::KIND_FIND_BLOCK) && !is_block_q);
  assign sts_o.head_valid     = hd_vld_q;
  assign sts_o.key_match      = (ek_q == key_q);
  assign sts_o.node_is_handle = (cur_q == handle_q);
  assign sts_o.link_valid     = lk_q[cht_pkg::LINK_W-1];
  assign sts_o.steps_last     = (steps_q == cht_pkg::STEP_W'(cht_pkg::POOL_ENTRIES - 1));
  assign sts_o.out_free       = !out_valid_q || out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign out_status_o   = out_status_q;
  assign out_handle_o   = out_handle_q;
  assign out_is_dir_o   = out_dir_q;
  assign out_is_file_o  = out_file_q;
  assign out_is_block_o = out_block_q;

endmodule

`default_nettype wire
